FILE: rtl/core/face_normal_packer_core_macros.svh
// Assertion macros shared by the face normal packer checker.
`ifndef FACE_NORMAL_PACKER_CORE_MACROS_SVH
`define FACE_NORMAL_PACKER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define FNP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define FNP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/fnp_pkg.sv
// Shared types and constants of the face normal packer.
package fnp_pkg;

    localparam int NUM_COMP = 3;
    localparam int BYTE_W   = 8;

    localparam logic [1:0] COMP_LAST = 2'd2;
    localparam logic [2:0] BIT_TOP   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_INIT,
        ST_SUM,
        ST_DECIDE,
        ST_FINISH
    } t_state;

    // Issue slots of the shared multiplier: cross product terms, then the
    // three partial products of each component square.
    typedef enum logic [3:0] {
        MS_NX_A,
        MS_NX_B,
        MS_NY_A,
        MS_NY_B,
        MS_NZ_A,
        MS_NZ_B,
        MS_X_HH,
        MS_X_HL,
        MS_X_LL,
        MS_Y_HH,
        MS_Y_HL,
        MS_Y_LL,
        MS_Z_HH,
        MS_Z_HL,
        MS_Z_LL
    } t_mstep;

    typedef struct packed {
        logic       mac_go;
        t_mstep     mac_step;
        logic       s_init;
        logic       s_sum;
        logic       s_decide;
        logic [1:0] comp;
        logic [2:0] bit_idx;
    } t_ctl;

endpackage

FILE: rtl/core/fnp_ctrl.sv
// Sequencer of the face normal packer: multiplier slots and search steps.
module fnp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_zero,
    input  logic          i_out_free,
    output logic          o_in_ready,
    output logic          o_load,
    output fnp_pkg::t_ctl o_ctl
);

    fnp_pkg::t_state r_state, n_state;
    fnp_pkg::t_mstep r_mstep, n_mstep;
    logic [1:0]      r_comp, n_comp;
    logic [2:0]      r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fnp_pkg::ST_IDLE;
            r_mstep <= fnp_pkg::MS_NX_A;
            r_comp  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_mstep <= n_mstep;
            r_comp  <= n_comp;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_mstep        = r_mstep;
        n_comp         = r_comp;
        n_bit          = r_bit;
        o_in_ready     = 1'b0;
        o_load         = 1'b0;
        o_ctl          = '0;
        o_ctl.mac_step = r_mstep;
        o_ctl.comp     = r_comp;
        o_ctl.bit_idx  = r_bit;
        unique case (r_state)
            fnp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_mstep    = fnp_pkg::MS_NX_A;
                if (i_in_valid) begin
                    n_state = fnp_pkg::ST_MAC;
                end
            end
            fnp_pkg::ST_MAC: begin
                o_ctl.mac_go = 1'b1;
                if (r_mstep == fnp_pkg::MS_Z_LL) begin
                    n_state = fnp_pkg::ST_DRAIN;
                end else begin
                    n_mstep = fnp_pkg::t_mstep'(r_mstep + 4'd1);
                end
            end
            fnp_pkg::ST_DRAIN: begin
                // The last square lands here; the normal itself is long settled.
                n_comp = '0;
                if (i_zero) begin
                    n_state = fnp_pkg::ST_FINISH;
                end else begin
                    n_state = fnp_pkg::ST_INIT;
                end
            end
            fnp_pkg::ST_INIT: begin
                o_ctl.s_init = 1'b1;
                n_bit        = fnp_pkg::BIT_TOP;
                n_state      = fnp_pkg::ST_SUM;
            end
            fnp_pkg::ST_SUM: begin
                o_ctl.s_sum = 1'b1;
                n_state     = fnp_pkg::ST_DECIDE;
            end
            fnp_pkg::ST_DECIDE: begin
                o_ctl.s_decide = 1'b1;
                if (r_bit == 3'd0) begin
                    if (r_comp == fnp_pkg::COMP_LAST) begin
                        n_state = fnp_pkg::ST_FINISH;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = fnp_pkg::ST_INIT;
                    end
                end else begin
                    n_bit   = r_bit - 3'd1;
                    n_state = fnp_pkg::ST_SUM;
                end
            end
            fnp_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = fnp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fnp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/fnp_mac.sv
// Shared multiplier with accumulators for the cross product and the squares.
module fnp_mac #(
    parameter int  COORD_BITS = 16,
    localparam int EW = COORD_BITS + 1,
    localparam int NW = 2 * COORD_BITS + 2,
    localparam int SW = 4 * COORD_BITS + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fnp_pkg::t_ctl        i_ctl,
    input  logic signed [EW-1:0] i_e1 [fnp_pkg::NUM_COMP],
    input  logic signed [EW-1:0] i_e2 [fnp_pkg::NUM_COMP],
    output logic [NW-1:0]        o_n [fnp_pkg::NUM_COMP],
    output logic [SW-1:0]        o_sq [fnp_pkg::NUM_COMP],
    output logic [SW-1:0]        o_sum
);

    localparam int HW    = COORD_BITS + 1;
    localparam int MW    = COORD_BITS + 2;
    localparam int PW    = 2 * MW;
    localparam int HH_SH = 2 * HW;
    localparam int HL_SH = HW + 1;

    logic signed [MW-1:0] ce1 [fnp_pkg::NUM_COMP];
    logic signed [MW-1:0] ce2 [fnp_pkg::NUM_COMP];
    logic signed [MW-1:0] hi  [fnp_pkg::NUM_COMP];
    logic signed [MW-1:0] lo  [fnp_pkg::NUM_COMP];
    logic signed [MW-1:0] op_a, op_b;

    logic signed [PW-1:0] r_prod;
    logic                 r_go_d;
    fnp_pkg::t_mstep      r_step_d;
    logic [NW-1:0]        r_acc;
    logic [NW-1:0]        r_n [fnp_pkg::NUM_COMP];
    logic [SW-1:0]        r_sq_acc;
    logic [SW-1:0]        r_sq [fnp_pkg::NUM_COMP];
    logic [SW-1:0]        r_sum;
    logic [SW-1:0]        prod_ext, term_hh, term_hl;

    // Each component is split into a signed upper half and an unsigned
    // lower half so that its square takes three products of the same unit.
    always_comb begin
        for (int i = 0; i < fnp_pkg::NUM_COMP; i++) begin
            ce1[i] = {i_e1[i][EW-1], i_e1[i]};
            ce2[i] = {i_e2[i][EW-1], i_e2[i]};
            hi[i]  = {r_n[i][NW-1], r_n[i][NW-1:HW]};
            lo[i]  = {1'b0, r_n[i][HW-1:0]};
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_ctl.mac_step)
            fnp_pkg::MS_NX_A: begin op_a = ce1[1]; op_b = ce2[2]; end
            fnp_pkg::MS_NX_B: begin op_a = ce1[2]; op_b = ce2[1]; end
            fnp_pkg::MS_NY_A: begin op_a = ce1[2]; op_b = ce2[0]; end
            fnp_pkg::MS_NY_B: begin op_a = ce1[0]; op_b = ce2[2]; end
            fnp_pkg::MS_NZ_A: begin op_a = ce1[0]; op_b = ce2[1]; end
            fnp_pkg::MS_NZ_B: begin op_a = ce1[1]; op_b = ce2[0]; end
            fnp_pkg::MS_X_HH: begin op_a = hi[0];  op_b = hi[0];  end
            fnp_pkg::MS_X_HL: begin op_a = hi[0];  op_b = lo[0];  end
            fnp_pkg::MS_X_LL: begin op_a = lo[0];  op_b = lo[0];  end
            fnp_pkg::MS_Y_HH: begin op_a = hi[1];  op_b = hi[1];  end
            fnp_pkg::MS_Y_HL: begin op_a = hi[1];  op_b = lo[1];  end
            fnp_pkg::MS_Y_LL: begin op_a = lo[1];  op_b = lo[1];  end
            fnp_pkg::MS_Z_HH: begin op_a = hi[2];  op_b = hi[2];  end
            fnp_pkg::MS_Z_HL: begin op_a = hi[2];  op_b = lo[2];  end
            fnp_pkg::MS_Z_LL: begin op_a = lo[2];  op_b = lo[2];  end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Sums are kept modulo the register width; every final value fits.
    assign prod_ext = {{(SW-PW){r_prod[PW-1]}}, r_prod};
    assign term_hh  = prod_ext << HH_SH;
    assign term_hl  = prod_ext << HL_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go_d <= 1'b0;
        end else begin
            r_go_d <= i_ctl.mac_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= op_a * op_b;
        r_step_d <= i_ctl.mac_step;
        if (r_go_d) begin
            unique case (r_step_d)
                fnp_pkg::MS_NX_A, fnp_pkg::MS_NY_A, fnp_pkg::MS_NZ_A: begin
                    r_acc <= r_prod[NW-1:0];
                end
                fnp_pkg::MS_NX_B: r_n[0] <= r_acc - r_prod[NW-1:0];
                fnp_pkg::MS_NY_B: r_n[1] <= r_acc - r_prod[NW-1:0];
                fnp_pkg::MS_NZ_B: r_n[2] <= r_acc - r_prod[NW-1:0];
                fnp_pkg::MS_X_HH: begin
                    r_sq_acc <= term_hh;
                    r_sum    <= term_hh;
                end
                fnp_pkg::MS_Y_HH, fnp_pkg::MS_Z_HH: begin
                    r_sq_acc <= term_hh;
                    r_sum    <= r_sum + term_hh;
                end
                fnp_pkg::MS_X_HL, fnp_pkg::MS_Y_HL, fnp_pkg::MS_Z_HL: begin
                    r_sq_acc <= r_sq_acc + term_hl;
                    r_sum    <= r_sum + term_hl;
                end
                fnp_pkg::MS_X_LL: begin
                    r_sq[0] <= r_sq_acc + prod_ext;
                    r_sum   <= r_sum + prod_ext;
                end
                fnp_pkg::MS_Y_LL: begin
                    r_sq[1] <= r_sq_acc + prod_ext;
                    r_sum   <= r_sum + prod_ext;
                end
                fnp_pkg::MS_Z_LL: begin
                    r_sq[2] <= r_sq_acc + prod_ext;
                    r_sum   <= r_sum + prod_ext;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_n   = r_n;
    assign o_sq  = r_sq;
    assign o_sum = r_sum;

endmodule

FILE: rtl/core/fnp_qsearch.sv
// Bitwise search for each quantized byte using shift-add updated squares.
module fnp_qsearch #(
    parameter int  COORD_BITS = 16,
    localparam int SW = 4 * COORD_BITS + 4
) (
    input  logic                  i_clk,
    input  fnp_pkg::t_ctl         i_ctl,
    input  logic [fnp_pkg::NUM_COMP-1:0] i_neg,
    input  logic [SW-1:0]         i_sq [fnp_pkg::NUM_COMP],
    input  logic [SW-1:0]         i_sum,
    output logic [fnp_pkg::NUM_COMP*fnp_pkg::BYTE_W-1:0] o_bytes
);

    // Room for 255^2 times the squared length, plus one bit for the carries.
    localparam int AW = 4 * COORD_BITS + 21;

    logic [AW-1:0] sum_ext, sq_ext;
    logic [AW-1:0] init_a, init_b, init_n;
    logic [AW-1:0] n_t, n_bt;
    logic [AW-1:0] r_a, r_b, r_t, r_bt, r_n;
    logic [4:0]    sh_b, sh_s, sh_bt;
    logic          kpos, neg, ok;
    logic [fnp_pkg::BYTE_W-1:0] r_byte [fnp_pkg::NUM_COMP];

    assign sum_ext = {{(AW-SW){1'b0}}, i_sum};
    assign sq_ext  = {{(AW-SW){1'b0}}, i_sq[i_ctl.comp]};

    // Start at the lowest byte: k = -255, so A = 65025*L^2 and B = -255*L^2.
    // 65025 is 2^16 - 2^9 + 1.
    assign init_a = (sum_ext << 16) - (sum_ext << 9) + sum_ext;
    assign init_b = sum_ext - (sum_ext << 8);
    assign init_n = (sq_ext << 16) - (sq_ext << 9) + sq_ext;

    // Raising k by d = 2^(j+1): (k+d)^2 S = A + 2dB + d^2 S, (k+d) S = B + dS.
    assign sh_b  = {2'b00, i_ctl.bit_idx} + 5'd2;
    assign sh_s  = {1'b0, i_ctl.bit_idx, 1'b0} + 5'd2;
    assign sh_bt = {2'b00, i_ctl.bit_idx} + 5'd1;
    assign n_t   = r_a + (r_b << sh_b) + (sum_ext << sh_s);
    assign n_bt  = r_b + (sum_ext << sh_bt);

    // The candidate k is positive once the byte reaches 128.
    assign kpos = (i_ctl.bit_idx == fnp_pkg::BIT_TOP) | r_byte[i_ctl.comp][fnp_pkg::BYTE_W-1];
    assign neg  = i_neg[i_ctl.comp];

    always_comb begin
        priority if (kpos && neg) begin
            ok = 1'b0;
        end else if (kpos) begin
            ok = (r_t <= r_n);
        end else if (neg) begin
            ok = (r_t >= r_n);
        end else begin
            ok = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s_init) begin
            r_a                 <= init_a;
            r_b                 <= init_b;
            r_n                 <= init_n;
            r_byte[i_ctl.comp]  <= '0;
        end
        if (i_ctl.s_sum) begin
            r_t  <= n_t;
            r_bt <= n_bt;
        end
        if (i_ctl.s_decide) begin
            r_byte[i_ctl.comp][i_ctl.bit_idx] <= ok;
            if (ok) begin
                r_a <= r_t;
                r_b <= r_bt;
            end
        end
    end

    assign o_bytes = {r_byte[0], r_byte[1], r_byte[2]};

endmodule

FILE: rtl/core/face_normal_packer_core.sv
// Top level of the face normal packer: quantized triangle normal in 24 bits.
//
//  Channel | Direction | tdata (low bit up)                      | tuser
//  s_axis  | in        | a_x a_y a_z b_x b_y b_z c_x c_y c_z     | -
//  m_axis  | out       | packed_normal                           | degenerate
//
// From its accept a triangle passes through the 15 issue slots of the single
// shared multiplier (six cross product terms and three partial products per
// component square) and a drain state; unless the cross product is zero, it
// then runs the 24 search steps of the shared shift-add/compare unit, each a
// sum state and a decide state, plus one setup state per component. One
// triangle is in flight at a time; the next is taken once the result has
// moved to the output register. Reset is synchronous and active low and
// clears only the sequencer, the multiplier's issue flag and the output
// valid flag. A stalled output holds the result and keeps the block from
// finishing the next triangle until the result is taken.
module face_normal_packer_core #(
    parameter int  COORD_BITS = 16,
    localparam int S_TDATA_W  = ((9 * COORD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = fnp_pkg::NUM_COMP * fnp_pkg::BYTE_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
    // vertex_c_x, vertex_c_y, vertex_c_z, each COORD_BITS wide, zero padded.
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // packed_normal
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0]           m_axis_tuser
);

    localparam int EW = COORD_BITS + 1;
    localparam int NW = 2 * COORD_BITS + 2;
    localparam int SW = 4 * COORD_BITS + 4;

    logic signed [COORD_BITS-1:0] va [fnp_pkg::NUM_COMP];
    logic signed [COORD_BITS-1:0] vb [fnp_pkg::NUM_COMP];
    logic signed [COORD_BITS-1:0] vc [fnp_pkg::NUM_COMP];
    logic signed [EW-1:0]         n_e1 [fnp_pkg::NUM_COMP];
    logic signed [EW-1:0]         n_e2 [fnp_pkg::NUM_COMP];
    logic signed [EW-1:0]         r_e1 [fnp_pkg::NUM_COMP];
    logic signed [EW-1:0]         r_e2 [fnp_pkg::NUM_COMP];

    fnp_pkg::t_ctl ctl;
    logic          in_ready, load, out_free, zero;
    logic [NW-1:0] nrm [fnp_pkg::NUM_COMP];
    logic [SW-1:0] sq  [fnp_pkg::NUM_COMP];
    logic [SW-1:0] sum_sq;
    logic [fnp_pkg::NUM_COMP-1:0] neg;
    logic [M_TDATA_W-1:0] bytes;

    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic                 r_m_user;

    // Edge vectors from the first vertex are formed at accept time, so the
    // multiplier only ever sees the edge vectors.
    always_comb begin
        for (int i = 0; i < fnp_pkg::NUM_COMP; i++) begin
            va[i]   = s_axis_tdata[i * COORD_BITS +: COORD_BITS];
            vb[i]   = s_axis_tdata[(i + 3) * COORD_BITS +: COORD_BITS];
            vc[i]   = s_axis_tdata[(i + 6) * COORD_BITS +: COORD_BITS];
            n_e1[i] = {vb[i][COORD_BITS-1], vb[i]} - {va[i][COORD_BITS-1], va[i]};
            n_e2[i] = {vc[i][COORD_BITS-1], vc[i]} - {va[i][COORD_BITS-1], va[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && in_ready) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
        end
    end

    fnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_zero     (zero),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_load     (load),
        .o_ctl      (ctl)
    );

    fnp_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_e1    (r_e1),
        .i_e2    (r_e2),
        .o_n     (nrm),
        .o_sq    (sq),
        .o_sum   (sum_sq)
    );

    assign neg  = {nrm[2][NW-1], nrm[1][NW-1], nrm[0][NW-1]};
    // A zero cross product means the vertices are collinear or coincident.
    assign zero = (nrm[0] == '0) && (nrm[1] == '0) && (nrm[2] == '0);

    fnp_qsearch #(
        .COORD_BITS (COORD_BITS)
    ) u_qsearch (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_neg   (neg),
        .i_sq    (sq),
        .i_sum   (sum_sq),
        .o_bytes (bytes)
    );

    // Output register: the result waits here while the next triangle is taken.
    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= zero ? '0 : bytes;
            r_m_user <= zero;
        end
    end

    assign s_axis_tready   = in_ready;
    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_user;

endmodule

FILE: rtl/core/fnp_checker.sv
// Port-level checks of the face normal packer, bound to the top level.
`include "face_normal_packer_core_macros.svh"

module fnp_checker #(
    parameter int  COORD_BITS = 16,
    localparam int M_TDATA_W  = fnp_pkg::NUM_COMP * fnp_pkg::BYTE_W
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]           m_axis_tuser
);

    // Out of reset the block is idle with no result pending.
    `FNP_ASSERT_RST(a_reset_idle, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

    // An accepted triangle keeps the input closed while it is worked on.
    `FNP_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input reopened right after a transaction")

    // A result never appears in the cycle right after an accept.
    `FNP_ASSERT(a_no_early_result, $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready), "result came too early")

    // A degenerate triangle reports a zero normal.
    `FNP_ASSERT(a_degenerate_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0, "degenerate result with nonzero normal")

    // A stalled result stays put.
    `FNP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind face_normal_packer_core fnp_checker #(
    .COORD_BITS (COORD_BITS)
) u_fnp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/tb.sv
// Self-checking testbench of the face normal packer core.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_W   = 16;
    localparam int S_DATA_W  = ((9 * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W  = fnp_pkg::NUM_COMP * fnp_pkg::BYTE_W;
    localparam int IDLE_PCT  = 18;
    localparam int RANDOM_N  = 750;
    localparam int TAIL_CYC  = 150;
    localparam int LIMIT_CYC = 600000;

    // Nine coordinates, vertex_a_x in element 0 (lowest bits of tdata).
    typedef logic [8:0][COORD_W-1:0] tri_t;

    typedef struct packed {
        logic [23:0] packed_normal;
        logic        degenerate;
    } normal_t;

    typedef enum int {
        SHAPE_ANY,
        SHAPE_TINY,
        SHAPE_LINE,
        SHAPE_FLAT,
        SHAPE_EXTREME,
        SHAPE_TILT
    } shape_t;

    class normal_scoreboard;
        normal_t expected_normals[$];
        int      fails = 0;

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            fails++;
        endtask

        function int pending();
            return expected_normals.size();
        endfunction

        // Largest q with (2q - 255) * L <= 255 * comp, found by comparing squares.
        function logic [7:0] quantize_component(longint comp, logic [127:0] len_sq);
            int          lo;
            int          hi;
            int          mid;
            int          k;
            bit          ok;
            logic [127:0] mag;
            logic [127:0] lhs;
            logic [127:0] rhs;
            lo  = 0;
            hi  = 256;
            mag = 128'(comp < 0 ? -comp : comp);
            rhs = mag * mag * 128'(65025);
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                k   = 2 * mid - 255;
                if (k >= 0 && comp < 0) begin
                    ok = 1'b0;
                end else if (k < 0 && comp >= 0) begin
                    ok = 1'b1;
                end else begin
                    lhs = len_sq * 128'(k * k);
                    ok  = (k >= 0) ? (lhs <= rhs) : (lhs >= rhs);
                end
                if (ok) lo = mid;
                else hi = mid;
            end
            return 8'(lo);
        endfunction

        function normal_t predict_normal(tri_t t);
            longint       v[9];
            longint       e1x, e1y, e1z, e2x, e2y, e2z;
            longint       nx, ny, nz;
            logic [127:0] mx, my, mz, len_sq;
            normal_t      r;
            for (int i = 0; i < 9; i++) v[i] = longint'($signed(t[i]));
            e1x = v[3] - v[0];
            e1y = v[4] - v[1];
            e1z = v[5] - v[2];
            e2x = v[6] - v[0];
            e2y = v[7] - v[1];
            e2z = v[8] - v[2];
            nx  = e1y * e2z - e1z * e2y;
            ny  = e1z * e2x - e1x * e2z;
            nz  = e1x * e2y - e1y * e2x;
            if (nx == 0 && ny == 0 && nz == 0) begin
                r.packed_normal = '0;
                r.degenerate    = 1'b1;
                return r;
            end
            mx     = 128'(nx < 0 ? -nx : nx);
            my     = 128'(ny < 0 ? -ny : ny);
            mz     = 128'(nz < 0 ? -nz : nz);
            len_sq = mx * mx + my * my + mz * mz;
            r.packed_normal = {quantize_component(nx, len_sq),
                               quantize_component(ny, len_sq),
                               quantize_component(nz, len_sq)};
            r.degenerate    = 1'b0;
            return r;
        endfunction

        function void note_triangle(logic [S_DATA_W-1:0] data);
            expected_normals.push_back(predict_normal(tri_t'(data)));
        endfunction

        task check_normal(logic [M_DATA_W-1:0] data, logic degen);
            normal_t want;
            if (expected_normals.size() == 0) begin
                report_mismatch($sformatf("unexpected result %06h degenerate %0b",
                                          data, degen));
                return;
            end
            want = expected_normals.pop_front();
            if (data !== want.packed_normal)
                report_mismatch($sformatf("packed_normal %06h, expected %06h",
                                          data, want.packed_normal));
            if (degen !== want.degenerate)
                report_mismatch($sformatf("degenerate %0b, expected %0b",
                                          degen, want.degenerate));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;

    normal_scoreboard sb;
    bit               calm;

    face_normal_packer_core #(
        .COORD_BITS(COORD_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYC) @(posedge i_clk);
        $display("FAIL face_normal_packer_core");
        $finish;
    end

    // The receiver stalls at random except during the calm stretch.
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Handshakes are sampled at the falling edge, where all signals are settled,
    // and stand for the transaction at the following rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            sb.note_triangle(s_axis_tdata);
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_normal(m_axis_tdata, m_axis_tuser[0]);
    end

    task automatic send_triangle(input tri_t t);
        bit ready_seen;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do begin
            @(negedge i_clk);
            ready_seen = s_axis_tready;
            @(posedge i_clk);
        end while (!ready_seen);
    endtask

    task automatic wait_all_results();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        tri_t t;
        t[0] = 16'(ax); t[1] = 16'(ay); t[2] = 16'(az);
        t[3] = 16'(bx); t[4] = 16'(by); t[5] = 16'(bz);
        t[6] = 16'(cx); t[7] = 16'(cy); t[8] = 16'(cz);
        return t;
    endfunction

    function automatic logic [15:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic tri_t random_triangle(shape_t shape);
        tri_t t;
        int   axis;
        int   k;
        int   d;
        for (int i = 0; i < 9; i++) t[i] = 16'($urandom);
        case (shape)
            SHAPE_TINY: begin
                for (int i = 3; i < 9; i++)
                    t[i] = 16'(int'($signed(t[i % 3])) + $urandom_range(0, 16) - 8);
            end
            SHAPE_LINE: begin
                // The third vertex lies on the line through the first two.
                k = $urandom_range(0, 6) - 3;
                for (int i = 0; i < 3; i++) begin
                    d        = $urandom_range(0, 40) - 20;
                    t[i]     = 16'($urandom_range(0, 8000) - 4000);
                    t[3 + i] = 16'(int'($signed(t[i])) + d);
                    t[6 + i] = 16'(int'($signed(t[i])) + k * d);
                end
            end
            SHAPE_FLAT, SHAPE_TILT: begin
                // All vertices share one coordinate, so the normal is on an axis;
                // a tilt nudges one vertex slightly off the plane.
                axis         = $urandom_range(0, 2);
                t[3 + axis]  = t[axis];
                t[6 + axis]  = t[axis];
                if (shape == SHAPE_TILT)
                    t[3 * $urandom_range(1, 2) + axis] =
                        16'(int'($signed(t[axis])) + $urandom_range(1, 3));
            end
            SHAPE_EXTREME: begin
                for (int i = 0; i < 9; i++) t[i] = extreme_coord();
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return SHAPE_ANY;
        if (r < 55) return SHAPE_TINY;
        if (r < 67) return SHAPE_LINE;
        if (r < 79) return SHAPE_FLAT;
        if (r < 90) return SHAPE_EXTREME;
        return SHAPE_TILT;
    endfunction

    initial begin
        tri_t directed[$];
        sb            = new();
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Degenerate triangles: all at the origin, one repeated point, a line.
        directed.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_tri(123, -45, 6, 123, -45, 6, 123, -45, 6));
        directed.push_back(make_tri(1, 2, 3, 3, 5, 7, 7, 11, 15));
        directed.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767));
        // Normals along each axis in both directions.
        directed.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        directed.push_back(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
        directed.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        directed.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
        // Equal components.
        directed.push_back(make_tri(0, 0, 0, 1, -1, 0, 0, 1, -1));
        // Coordinate extremes, largest edges and the largest cross product.
        directed.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                    -32768, 32767, -32768));
        directed.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                    32767, 32767, -32768));
        directed.push_back(make_tri(32767, -32768, 0, -32768, 32767, 32767,
                                    0, 0, -32768));
        directed.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                    -32768, -32768, 32767));
        directed.push_back(make_tri(-1, -1, -1, 32767, -32768, -1, -32768, -1, 32767));
        // A nearly flat triangle with a tiny tilt.
        directed.push_back(make_tri(-30000, -30000, 5, 30000, -30000, 5,
                                    -30000, 30000, 6));
        foreach (directed[i]) send_triangle(directed[i]);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_all_results();

        for (int n = 0; n < RANDOM_N; n++) begin
            calm = (n >= 300 && n < 420);
            if (n == 500) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                wait_all_results();
            end
            send_triangle(random_triangle(pick_shape()));
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        wait_all_results();
        repeat (TAIL_CYC) @(posedge i_clk);

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("PASS face_normal_packer_core");
        end else begin
            $display("FAIL face_normal_packer_core");
        end
        $finish;
    end

endmodule
